[rtl/okrx_pkg.sv]
// shared types, rotate table and rotate helpers for the offset-keyed rotate/xor cipher
package okrx_pkg;

    localparam int WordWidth   = 32;
    localparam int NumWords    = 4;
    localparam int OffsetWidth = 9;
    localparam int AmtWidth    = 5;
    localparam int BlkWidth    = 5;
    localparam int PivotWidth  = 4;
    localparam int BlockBits   = WordWidth * NumWords;

    localparam logic [7:0] AmtMask = 8'hA5;

    localparam logic [7:0] RotTable [32] = '{
        8'hA4, 8'hA7, 8'hA6, 8'hA1, 8'hA0, 8'hA3, 8'hA2, 8'hAC,
        8'hAF, 8'hAE, 8'hA9, 8'hA8, 8'hAB, 8'hAA, 8'hB4, 8'hB7,
        8'hB6, 8'hB1, 8'hB0, 8'hB3, 8'hB2, 8'hBC, 8'hBF, 8'hBE,
        8'hB9, 8'hB8, 8'hBB, 8'hBA, 8'hA1, 8'hA9, 8'hB1, 8'hB9
    };

    // table position offsets for the data and key rotates
    localparam logic [BlkWidth-1:0] AddKey0  = 5'd0;
    localparam logic [BlkWidth-1:0] AddKey1  = 5'd3;
    localparam logic [BlkWidth-1:0] AddKey2  = 5'd6;
    localparam logic [BlkWidth-1:0] AddKey3  = 5'd9;
    localparam logic [BlkWidth-1:0] AddData0 = 5'd12;
    localparam logic [BlkWidth-1:0] AddData1 = 5'd15;
    localparam logic [BlkWidth-1:0] AddData2 = 5'd18;
    localparam logic [BlkWidth-1:0] AddData3 = 5'd21;

    typedef enum logic [1:0] {
        REG_KEY_WORD0 = 2'd0,
        REG_KEY_WORD1 = 2'd1,
        REG_KEY_WORD2 = 2'd2,
        REG_KEY_WORD3 = 2'd3
    } reg_index_t;

    typedef enum logic {
        MODE_ENCRYPT = 1'b0,
        MODE_DECRYPT = 1'b1
    } mode_t;

    typedef logic [NumWords-1:0][WordWidth-1:0] key_set_t;

    typedef struct packed {
        logic                   mode;
        logic [WordWidth-1:0]   in_word0;
        logic [WordWidth-1:0]   in_word1;
        logic [WordWidth-1:0]   in_word2;
        logic [WordWidth-1:0]   in_word3;
        logic [OffsetWidth-1:0] byte_offset;
    } item_t;

    typedef struct packed {
        logic [WordWidth-1:0] out_word0;
        logic [WordWidth-1:0] out_word1;
        logic [WordWidth-1:0] out_word2;
        logic [WordWidth-1:0] out_word3;
    } result_t;

    function automatic logic [AmtWidth-1:0] rot_amount(
        input logic [BlkWidth-1:0] blk,
        input logic [BlkWidth-1:0] add
    );
        logic [BlkWidth-1:0] idx;
        logic [7:0]          raw;
        idx = blk + add;
        raw = RotTable[idx] ^ AmtMask;
        return raw[AmtWidth-1:0];
    endfunction

    function automatic logic [WordWidth-1:0] rol32(
        input logic [WordWidth-1:0] v,
        input logic [AmtWidth-1:0]  s
    );
        logic [2*WordWidth-1:0] d;
        d = {v, v} << s;
        return d[2*WordWidth-1:WordWidth];
    endfunction

    function automatic logic [WordWidth-1:0] ror32(
        input logic [WordWidth-1:0] v,
        input logic [AmtWidth-1:0]  s
    );
        logic [2*WordWidth-1:0] d;
        d = {v, v} >> s;
        return d[WordWidth-1:0];
    endfunction

endpackage

[rtl/okrx_keys.sv]
// key word register file with a plain write port
module okrx_keys (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [okrx_pkg::WordWidth-1:0]      cfg_data,
    output okrx_pkg::key_set_t                  keys
);

    okrx_pkg::key_set_t key_reg;
    okrx_pkg::key_set_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            case (okrx_pkg::reg_index_t'(cfg_index))
                okrx_pkg::REG_KEY_WORD0: key_next[0] = cfg_data;
                okrx_pkg::REG_KEY_WORD1: key_next[1] = cfg_data;
                okrx_pkg::REG_KEY_WORD2: key_next[2] = cfg_data;
                okrx_pkg::REG_KEY_WORD3: key_next[3] = cfg_data;
                default:                 key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign keys = key_reg;

endmodule

[rtl/okrx_round.sv]
// single-pass encrypt/decrypt logic for one 16-byte block
module okrx_round (
    input  okrx_pkg::item_t    item,
    input  okrx_pkg::key_set_t keys,
    output okrx_pkg::result_t  result
);

    logic [okrx_pkg::BlkWidth-1:0]   blk;
    logic [okrx_pkg::PivotWidth-1:0] pivot;
    logic [okrx_pkg::AmtWidth-1:0]   amt_k0, amt_k1, amt_k2, amt_k3;
    logic [okrx_pkg::AmtWidth-1:0]   amt_d0, amt_d1, amt_d2, amt_d3;
    logic [okrx_pkg::WordWidth-1:0]  rk0, rk1, rk2, rk3;
    logic [okrx_pkg::WordWidth-1:0]  e0, e1, e2, e3;
    logic [okrx_pkg::BlockBits-1:0]  enc_block;
    logic [okrx_pkg::BlockBits-1:0]  enc_spread;
    logic [okrx_pkg::BlockBits-1:0]  in_block;
    logic [okrx_pkg::BlockBits-1:0]  dec_spread;
    logic [okrx_pkg::BlockBits-1:0]  dec_block;
    logic [7:0]                      enc_src;
    logic [7:0]                      dec_src;
    logic [okrx_pkg::WordWidth-1:0]  d0, d1, d2, d3;
    logic [okrx_pkg::BlockBits-1:0]  enc_out;

    assign blk   = item.byte_offset[okrx_pkg::OffsetWidth-1:okrx_pkg::PivotWidth];
    assign pivot = item.byte_offset[okrx_pkg::PivotWidth-1:0];

    assign amt_k0 = okrx_pkg::rot_amount(blk, okrx_pkg::AddKey0);
    assign amt_k1 = okrx_pkg::rot_amount(blk, okrx_pkg::AddKey1);
    assign amt_k2 = okrx_pkg::rot_amount(blk, okrx_pkg::AddKey2);
    assign amt_k3 = okrx_pkg::rot_amount(blk, okrx_pkg::AddKey3);
    assign amt_d0 = okrx_pkg::rot_amount(blk, okrx_pkg::AddData0);
    assign amt_d1 = okrx_pkg::rot_amount(blk, okrx_pkg::AddData1);
    assign amt_d2 = okrx_pkg::rot_amount(blk, okrx_pkg::AddData2);
    assign amt_d3 = okrx_pkg::rot_amount(blk, okrx_pkg::AddData3);

    assign rk0 = okrx_pkg::ror32(keys[0], amt_k0);
    assign rk1 = okrx_pkg::rol32(keys[1], amt_k1);
    assign rk2 = okrx_pkg::ror32(keys[2], amt_k2);
    assign rk3 = okrx_pkg::rol32(keys[3], amt_k3);

    // encrypt: word rotates and key mix, then spread byte 0 over the rest
    assign e0 = okrx_pkg::rol32(item.in_word0, amt_d0) ^ rk0;
    assign e1 = okrx_pkg::ror32(item.in_word1, amt_d1) ^ rk1;
    assign e2 = okrx_pkg::rol32(item.in_word2, amt_d2) ^ rk2;
    assign e3 = okrx_pkg::ror32(item.in_word3, amt_d3) ^ rk3;

    assign enc_block  = {e3, e2, e1, e0};
    assign enc_src    = e0[7:0];
    assign enc_spread = {{(okrx_pkg::BlockBits/8-1){enc_src}}, 8'h00};
    assign enc_out    = enc_block ^ enc_spread;

    // decrypt: undo the byte spread around the pivot byte first
    assign in_block = {item.in_word3, item.in_word2, item.in_word1, item.in_word0};
    assign dec_src  = in_block[{pivot, 3'b000} +: 8];

    always_comb
    begin
        dec_spread = {(okrx_pkg::BlockBits/8){dec_src}};
        dec_spread[{pivot, 3'b000} +: 8] = 8'h00;
    end

    assign dec_block = in_block ^ dec_spread;

    assign d0 = okrx_pkg::ror32(dec_block[31:0]   ^ rk0, amt_d0);
    assign d1 = okrx_pkg::rol32(dec_block[63:32]  ^ rk1, amt_d1);
    assign d2 = okrx_pkg::ror32(dec_block[95:64]  ^ rk2, amt_d2);
    assign d3 = okrx_pkg::rol32(dec_block[127:96] ^ rk3, amt_d3);

    always_comb
    begin
        case (okrx_pkg::mode_t'(item.mode))
            okrx_pkg::MODE_ENCRYPT:
            begin
                result.out_word0 = enc_out[31:0];
                result.out_word1 = enc_out[63:32];
                result.out_word2 = enc_out[95:64];
                result.out_word3 = enc_out[127:96];
            end
            okrx_pkg::MODE_DECRYPT:
            begin
                result.out_word0 = d0;
                result.out_word1 = d1;
                result.out_word2 = d2;
                result.out_word3 = d3;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

[rtl/offset_keyed_rotate_xor_block_cipher_unit.sv]
// top level of the offset-keyed rotate/xor block cipher unit
// One 16-byte block is taken per start beat and its result appears on result with done
// high for exactly one cycle; a new block may be started every cycle, so busy stays low.
// The block passes through the input register and then the result register, with all
// the rotate and xor work for one block in the single logic pass between them.
// Results cannot be held off by the receiver, so it must take each done beat as it comes.
// Key words are written through cfg_we/cfg_index/cfg_data and must only change while
// no block is in flight.
module offset_keyed_rotate_xor_block_cipher_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  okrx_pkg::item_t                item,
    output logic                           done,
    output okrx_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [okrx_pkg::WordWidth-1:0] cfg_data
);

    okrx_pkg::key_set_t keys;
    okrx_pkg::item_t    item_reg;
    logic               item_valid_reg;
    okrx_pkg::result_t  result_next;
    okrx_pkg::result_t  result_reg;
    logic               done_reg;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    okrx_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    okrx_round u_round (
        .item   (item_reg),
        .keys   (keys),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
            done_reg       <= item_valid_reg;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_accept_loads : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_valid_reg)
        else $error("accepted beat did not reach the input register");

    a_valid_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |=> done)
        else $error("registered block produced no result beat");

    a_done_from_accept : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result beat without a started block");

    a_result_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |=> $stable(result))
        else $error("result changed with no block in flight");

endmodule

[bench/offset_keyed_rotate_xor_block_cipher_unit_tb.sv]
// self-checking testbench for the offset-keyed rotate/xor block cipher unit
`timescale 1ns / 1ps

module offset_keyed_rotate_xor_block_cipher_unit_tb;

    localparam int Latency    = 2;
    localparam int CycleLimit = 200000;
    localparam int NumPhases  = 6;
    localparam int PhaseItems = 100;
    localparam int NumRows    = 18;

    localparam logic [7:0] RotBytes [32] = '{
        8'hA4, 8'hA7, 8'hA6, 8'hA1, 8'hA0, 8'hA3, 8'hA2, 8'hAC,
        8'hAF, 8'hAE, 8'hA9, 8'hA8, 8'hAB, 8'hAA, 8'hB4, 8'hB7,
        8'hB6, 8'hB1, 8'hB0, 8'hB3, 8'hB2, 8'hBC, 8'hBF, 8'hBE,
        8'hB9, 8'hB8, 8'hBB, 8'hBA, 8'hA1, 8'hA9, 8'hB1, 8'hB9
    };

    // sender idle percentage per phase, repeated over the phases
    localparam int PhaseIdle [3] = '{0, 86, 33};

    typedef struct packed {
        okrx_pkg::item_t   blk;
        logic              chk;
        okrx_pkg::result_t res;
    } vector_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    okrx_pkg::item_t   item      = '0;
    logic              done;
    okrx_pkg::result_t result;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = okrx_pkg::REG_KEY_WORD0;
    logic [okrx_pkg::WordWidth-1:0] cfg_data = '0;

    logic [31:0]       key_shadow [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
    okrx_pkg::result_t pending_blocks [$];
    int          errors      = 0;
    int          cycle_count = 0;
    int          idle_pct    = 0;
    int          burst_left  = 0;

    // directed blocks; typed-in results hold for the reset key of zero
    vector_t dir_vec [NumRows] = '{
        {okrx_pkg::MODE_ENCRYPT, 32'h0, 32'h0, 32'h0, 32'h0, 9'h000,
         1'b1, 32'h0, 32'h0, 32'h0, 32'h0},
        {okrx_pkg::MODE_DECRYPT, 32'h0, 32'h0, 32'h0, 32'h0, 9'h000,
         1'b1, 32'h0, 32'h0, 32'h0, 32'h0},
        {okrx_pkg::MODE_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
         9'h000, 1'b1, 32'h000000FF, 32'h0, 32'h0, 32'h0},
        {okrx_pkg::MODE_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
         9'h1FF, 1'b1, 32'h000000FF, 32'h0, 32'h0, 32'h0},
        {okrx_pkg::MODE_DECRYPT, 32'h0, 32'h0, 32'h0, 32'h0, 9'h1FF,
         1'b1, 32'h0, 32'h0, 32'h0, 32'h0},
        {okrx_pkg::MODE_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
         9'h000, 1'b0, 128'h0},
        {okrx_pkg::MODE_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
         9'h00F, 1'b0, 128'h0},
        {okrx_pkg::MODE_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
         9'h1F6, 1'b0, 128'h0},
        {okrx_pkg::MODE_ENCRYPT, 32'h00000001, 32'h80000000, 32'h00000001, 32'h80000000,
         9'h000, 1'b0, 128'h0},
        {okrx_pkg::MODE_ENCRYPT, 32'h80000000, 32'h00000001, 32'h80000000, 32'h00000001,
         9'h1F0, 1'b0, 128'h0},
        {okrx_pkg::MODE_ENCRYPT, 32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210,
         9'h0C7, 1'b0, 128'h0},
        {okrx_pkg::MODE_DECRYPT, 32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210,
         9'h0C7, 1'b0, 128'h0},
        {okrx_pkg::MODE_DECRYPT, 32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00,
         9'h104, 1'b0, 128'h0},
        {okrx_pkg::MODE_DECRYPT, 32'h000000FF, 32'h0000FF00, 32'h00FF0000, 32'hFF000000,
         9'h008, 1'b0, 128'h0},
        {okrx_pkg::MODE_ENCRYPT, 32'hA5A5A5A5, 32'hA5A5A5A5, 32'hA5A5A5A5, 32'hA5A5A5A5,
         9'h150, 1'b0, 128'h0},
        {okrx_pkg::MODE_DECRYPT, 32'h5A5A5A5A, 32'h5A5A5A5A, 32'h5A5A5A5A, 32'h5A5A5A5A,
         9'h1EB, 1'b0, 128'h0},
        {okrx_pkg::MODE_ENCRYPT, 32'h13579BDF, 32'h2468ACE0, 32'hFDB97531, 32'h0ECA8642,
         9'h0F0, 1'b0, 128'h0},
        {okrx_pkg::MODE_DECRYPT, 32'hC3000000, 32'h00C30000, 32'h0000C300, 32'h000000C3,
         9'h00D, 1'b0, 128'h0}
    };

    offset_keyed_rotate_xor_block_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
        int unsigned n;
        n = s % 32;
        if (n == 0)
            return v;
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] rotr(logic [31:0] v, int unsigned s);
        int unsigned n;
        n = s % 32;
        if (n == 0)
            return v;
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic int unsigned rot_amt(logic [4:0] blk, logic [4:0] add);
        logic [4:0] idx;
        logic [7:0] amt;
        idx = blk + add;
        amt = RotBytes[idx] ^ 8'hA5;
        return amt;
    endfunction

    function automatic okrx_pkg::result_t cipher_block(okrx_pkg::item_t b);
        logic [31:0] w [4];
        logic [4:0]  blk;
        logic [3:0]  piv;
        logic [7:0]  pb;
        logic [31:0] rep;
        logic [31:0] m;
        okrx_pkg::result_t r;
        w[0] = b.in_word0;
        w[1] = b.in_word1;
        w[2] = b.in_word2;
        w[3] = b.in_word3;
        blk  = b.byte_offset[8:4];
        if (b.mode == okrx_pkg::MODE_ENCRYPT)
        begin
            w[0] = rotl(w[0], rot_amt(blk, 5'd12))
                 ^ rotr(key_shadow[okrx_pkg::REG_KEY_WORD0], rot_amt(blk, 5'd0));
            w[1] = rotr(w[1], rot_amt(blk, 5'd15))
                 ^ rotl(key_shadow[okrx_pkg::REG_KEY_WORD1], rot_amt(blk, 5'd3));
            w[2] = rotl(w[2], rot_amt(blk, 5'd18))
                 ^ rotr(key_shadow[okrx_pkg::REG_KEY_WORD2], rot_amt(blk, 5'd6));
            w[3] = rotr(w[3], rot_amt(blk, 5'd21))
                 ^ rotl(key_shadow[okrx_pkg::REG_KEY_WORD3], rot_amt(blk, 5'd9));
            // byte 0 spreads over the rest of the block, pivot bits unused
            rep  = {4{w[0][7:0]}};
            w[0] = w[0] ^ {rep[31:8], 8'h00};
            w[1] = w[1] ^ rep;
            w[2] = w[2] ^ rep;
            w[3] = w[3] ^ rep;
        end
        else
        begin
            piv = b.byte_offset[3:0];
            pb  = w[piv[3:2]][{piv[1:0], 3'b000} +: 8];
            rep = {4{pb}};
            for (int i = 0; i < 4; i++)
            begin
                m = rep;
                if (i == piv[3:2])
                    m[{piv[1:0], 3'b000} +: 8] = 8'h00;
                w[i] = w[i] ^ m;
            end
            w[0] = rotr(w[0] ^ rotr(key_shadow[okrx_pkg::REG_KEY_WORD0], rot_amt(blk, 5'd0)),
                        rot_amt(blk, 5'd12));
            w[1] = rotl(w[1] ^ rotl(key_shadow[okrx_pkg::REG_KEY_WORD1], rot_amt(blk, 5'd3)),
                        rot_amt(blk, 5'd15));
            w[2] = rotr(w[2] ^ rotr(key_shadow[okrx_pkg::REG_KEY_WORD2], rot_amt(blk, 5'd6)),
                        rot_amt(blk, 5'd18));
            w[3] = rotl(w[3] ^ rotl(key_shadow[okrx_pkg::REG_KEY_WORD3], rot_amt(blk, 5'd9)),
                        rot_amt(blk, 5'd21));
        end
        r.out_word0 = w[0];
        r.out_word1 = w[1];
        r.out_word2 = w[2];
        r.out_word3 = w[3];
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic check_word(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // one beat per call; returns at the falling edge after acceptance
    task automatic send_block(okrx_pkg::item_t b, okrx_pkg::result_t want);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 39) == 0)
                burst_left = $urandom_range(10, 40);
            while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        item  <= b;
        do
            @(posedge clk);
        while (busy);
        pending_blocks.push_back(want);
        @(negedge clk);
    endtask

    task automatic drain_blocks();
        start <= 1'b0;
        while (pending_blocks.size() > 0)
            @(negedge clk);
        repeat (Latency + 2) @(negedge clk);
    endtask

    task automatic load_keys(logic [31:0] k [4]);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= k[i];
            @(posedge clk);
            key_shadow[i] = k[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        okrx_pkg::result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("result beat with no block pending: %h", result);
                errors++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                check_word("out_word0", want.out_word0, result.out_word0);
                check_word("out_word1", want.out_word1, result.out_word1);
                check_word("out_word2", want.out_word2, result.out_word2);
                check_word("out_word3", want.out_word3, result.out_word3);
            end
        end
    end

    initial
    begin
        okrx_pkg::item_t   nb;
        okrx_pkg::result_t last_cipher;
        logic [8:0]  last_off;
        bit          have_cipher;
        logic [31:0] keys [4];

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < NumRows; r++)
        begin
            if (dir_vec[r].chk)
                send_block(dir_vec[r].blk, dir_vec[r].res);
            else
                send_block(dir_vec[r].blk, cipher_block(dir_vec[r].blk));
        end

        for (int ph = 0; ph < NumPhases; ph++)
        begin
            drain_blocks();
            case (ph)
                0: keys = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
                2: keys = '{32'h00000001, 32'h80000000, 32'h00000001, 32'h80000000};
                3: keys = '{32'h0, 32'h0, 32'h0, 32'h0};
                default: keys = '{$urandom, $urandom, $urandom, $urandom};
            endcase
            load_keys(keys);
            idle_pct    = PhaseIdle[ph % 3];
            burst_left  = 0;
            have_cipher = 0;
            for (int n = 0; n < PhaseItems; n++)
            begin
                if (have_cipher && $urandom_range(0, 99) < 40)
                begin
                    // feed the last ciphertext back at its aligned offset
                    nb.mode        = okrx_pkg::MODE_DECRYPT;
                    nb.in_word0    = last_cipher.out_word0;
                    nb.in_word1    = last_cipher.out_word1;
                    nb.in_word2    = last_cipher.out_word2;
                    nb.in_word3    = last_cipher.out_word3;
                    nb.byte_offset = {last_off[8:4], 4'h0};
                    have_cipher    = 0;
                end
                else
                begin
                    nb.mode        = 1'($urandom_range(0, 1));
                    nb.in_word0    = rand_word();
                    nb.in_word1    = rand_word();
                    nb.in_word2    = rand_word();
                    nb.in_word3    = rand_word();
                    nb.byte_offset = 9'($urandom_range(0, 511));
                    if (nb.mode == okrx_pkg::MODE_ENCRYPT)
                    begin
                        last_cipher = cipher_block(nb);
                        last_off    = nb.byte_offset;
                        have_cipher = 1;
                    end
                end
                send_block(nb, cipher_block(nb));
                if ($urandom_range(0, 99) == 0)
                    drain_blocks();
            end
        end

        drain_blocks();
        repeat (Latency + 8) @(posedge clk);
        if (errors == 0 && pending_blocks.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
